### rtl/mdf_pkg.sv
package mdf_pkg;

    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME    = 32'd16777619;
    localparam logic [15:0] WINDOW_RESET = 16'd5000;

    localparam logic [1:0] DROP_NONE = 2'd0;
    localparam logic [1:0] DROP_DUP  = 2'd1;
    localparam logic [1:0] DROP_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] tstamp;
        logic [31:0] id;
    } t_entry;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] id;
        logic [31:0] now;
        logic        full;
        logic        hit;
    } t_query;

endpackage

### rtl/mdf_in_if.sv
interface mdf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [31:0] message_id;
    logic [31:0] now_ms;
    logic        queue_full;

    modport source (
        output valid, msg_byte, byte_valid, last_byte, message_id, now_ms, queue_full,
        input  ready
    );
    modport sink (
        input  valid, msg_byte, byte_valid, last_byte, message_id, now_ms, queue_full,
        output ready
    );
endinterface

### rtl/mdf_out_if.sv
interface mdf_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  drop_reason;
    logic [31:0] message_hash;

    modport source (
        output valid, accepted, drop_reason, message_hash,
        input  ready
    );
    modport sink (
        input  valid, accepted, drop_reason, message_hash,
        output ready
    );
endinterface

### rtl/mdf_cfg_if.sv
interface mdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] dedup_window_ms;

    modport source (
        output valid, dedup_window_ms,
        input  ready
    );
    modport sink (
        input  valid, dedup_window_ms,
        output ready
    );
endinterface

### rtl/mdf_hash.sv
module mdf_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic        i_byte_valid,
    input  logic        i_last,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_fold
);

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] w_mixed;

    assign w_mixed = r_hash ^ {24'd0, i_byte};
    assign o_fold  = i_byte_valid ? 32'(w_mixed * mdf_pkg::FNV_PRIME) : r_hash;

    always_comb begin
        n_hash = r_hash;
        if (i_take) begin
            n_hash = i_last ? mdf_pkg::FNV_BASIS : o_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= mdf_pkg::FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

### rtl/mdf_cell.sv
module mdf_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_insert,
    input  logic [15:0]     i_window,
    input  mdf_pkg::t_query i_q,
    input  mdf_pkg::t_entry i_entry,
    output mdf_pkg::t_query o_q,
    output mdf_pkg::t_entry o_entry
);

    mdf_pkg::t_query r_q;
    mdf_pkg::t_query n_q;
    mdf_pkg::t_entry r_entry;
    logic [31:0]     w_age;
    logic            w_same;
    logic            w_hit;

    // match of the passing query against this entry
    assign w_age  = i_q.now - r_entry.tstamp;
    assign w_same = (r_entry.hash == i_q.hash) ||
                    ((i_q.id != 32'd0) && (r_entry.id == i_q.id));
    assign w_hit  = w_same && (w_age < {16'd0, i_window});

    always_comb begin
        n_q     = i_q;
        n_q.hit = i_q.hit | w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_insert) begin
            r_entry <= i_entry;
        end
    end

    assign o_q     = r_q;
    assign o_entry = r_entry;

endmodule

### rtl/message_dedup_filter_core.sv
// a byte that is not last is folded into the registered hash; the last word of a message
// launches a query down the registered cell chain, and its result is registered once the
// query leaves the last cell and the output is free; throughput: 1 word per cycle within a
// message, one message check at a time; no new word is taken while a check runs
// reset (synchronous, active low) clears the cache to zeros, the hash to the offset basis
// and the window to 5000
module message_dedup_filter_core #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdf_in_if.sink      i_in,
    mdf_out_if.source   o_out,
    mdf_cfg_if.sink     i_cfg
);

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [15:0]      r_window;

    mdf_pkg::t_query  r_launch;
    mdf_pkg::t_query  w_q [CACHE_ENTRIES];
    mdf_pkg::t_entry  w_e [CACHE_ENTRIES];
    mdf_pkg::t_query  w_final;
    mdf_pkg::t_entry  w_new;

    logic        w_take;
    logic [31:0] w_fold;
    logic        w_shift;
    logic        w_finish;
    logic        w_insert;

    logic        r_out_valid;
    logic        r_accepted;
    logic [1:0]  r_reason;
    logic [31:0] r_hash;
    logic [1:0]  n_reason;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_take      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= mdf_pkg::WINDOW_RESET;
        end else if (i_cfg.valid) begin
            r_window <= i_cfg.dedup_window_ms;
        end
    end

    mdf_hash u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_byte_valid (i_in.byte_valid),
        .i_last       (i_in.last_byte),
        .i_byte       (i_in.msg_byte),
        .o_fold       (w_fold)
    );

    always_ff @(posedge i_clk) begin
        if (w_take && i_in.last_byte) begin
            r_launch <= '{hash: w_fold, id: i_in.message_id, now: i_in.now_ms,
                          full: i_in.queue_full, hit: 1'b0};
        end
    end

    assign w_shift  = (r_state == ST_SCAN);
    assign w_final  = w_q[CACHE_ENTRIES-1];
    assign w_finish = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign w_insert = w_finish && !w_final.hit && !w_final.full;

    assign w_new.hash   = w_final.hash;
    assign w_new.tstamp = w_final.now;
    assign w_new.id     = w_final.id;

    // newest entry enters cell 0, the oldest falls off the far end
    for (genvar gi = 0; gi < CACHE_ENTRIES; gi++) begin : g_cell
        mdf_pkg::t_query w_qin;
        mdf_pkg::t_entry w_ein;
        if (gi == 0) begin : g_head
            assign w_qin = r_launch;
            assign w_ein = w_new;
        end else begin : g_body
            assign w_qin = w_q[gi-1];
            assign w_ein = w_e[gi-1];
        end
        mdf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_insert (w_insert),
            .i_window (r_window),
            .i_q      (w_qin),
            .i_entry  (w_ein),
            .o_q      (w_q[gi]),
            .o_entry  (w_e[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_take && i_in.last_byte) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CACHE_ENTRIES - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        if (w_final.hit) begin
            n_reason = mdf_pkg::DROP_DUP;
        end else if (w_final.full) begin
            n_reason = mdf_pkg::DROP_FULL;
        end else begin
            n_reason = mdf_pkg::DROP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_accepted <= w_insert;
            r_reason   <= n_reason;
            r_hash     <= w_final.hash;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.accepted     = r_accepted;
    assign o_out.drop_reason  = r_reason;
    assign o_out.message_hash = r_hash;

endmodule
